/* src/tgad_pkg.sv */
package tgad_pkg;

  localparam int unsigned HeaderLast = 17;
  localparam logic [4:0] HdrIdLen    = 5'd0;
  localparam logic [4:0] HdrMapType  = 5'd1;
  localparam logic [4:0] HdrTypeCode = 5'd2;
  localparam logic [4:0] HdrWidthLo  = 5'd12;
  localparam logic [4:0] HdrWidthHi  = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrBpp      = 5'd16;
  localparam logic [4:0] HdrFinal    = 5'(HeaderLast);

  localparam logic [7:0] TypeTruecolor = 8'd2;
  localparam logic [7:0] MapNone       = 8'd0;
  localparam logic [7:0] Bpp24         = 8'd24;
  localparam logic [7:0] Bpp32         = 8'd32;
  localparam logic [7:0] AlphaOpaque   = 8'hFF;

  localparam logic ErrNotTruecolor = 1'b0;
  localparam logic ErrBadDepth     = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_IDSKIP = 4'b0100,
    PH_PIXELS = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
    logic        error_code;
    logic        last;
  } result_t;

endpackage

/* src/tgad_parser.sv */
module tgad_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  output logic              res_valid,
  output tgad_pkg::result_t res
);

  tgad_pkg::phase_t phase, phase_next, phase_eff;
  logic [4:0]  header_index, header_index_next, hidx_eff;
  logic [7:0]  id_skip, id_skip_next;
  logic        type_ok, type_ok_next;
  logic        bpp_ok, bpp_ok_next;
  logic        bpp_is_32, bpp_is_32_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [1:0]  channel_index, channel_index_next;
  logic [23:0] held, held_next, held_new;
  logic [31:0] pixel_count;
  logic        emit_pixel;

  assign pixel_count = width_reg * height_reg;

  always_comb begin
    phase_eff          = start_of_file ? tgad_pkg::PH_HEADER : phase;
    hidx_eff           = start_of_file ? 5'd0 : header_index;
    phase_next         = phase_eff;
    header_index_next  = hidx_eff;
    id_skip_next       = id_skip;
    type_ok_next       = type_ok;
    bpp_ok_next        = bpp_ok;
    bpp_is_32_next     = bpp_is_32;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    pixels_left_next   = pixels_left;
    channel_index_next = channel_index;
    held_next          = held;
    held_new           = held;
    emit_pixel         = 1'b0;
    res_valid          = 1'b0;
    res                = '0;

    case (phase_eff)
      tgad_pkg::PH_HEADER: begin
        case (hidx_eff)
          tgad_pkg::HdrIdLen:    id_skip_next = data_byte;
          tgad_pkg::HdrMapType:  type_ok_next = (data_byte == tgad_pkg::MapNone);
          tgad_pkg::HdrTypeCode: begin
            if (data_byte != tgad_pkg::TypeTruecolor) type_ok_next = 1'b0;
          end
          tgad_pkg::HdrWidthLo:  width_reg_next = {8'd0, data_byte};
          tgad_pkg::HdrWidthHi:  width_reg_next[15:8] = data_byte;
          tgad_pkg::HdrHeightLo: height_reg_next = {8'd0, data_byte};
          tgad_pkg::HdrHeightHi: height_reg_next[15:8] = data_byte;
          tgad_pkg::HdrBpp: begin
            bpp_is_32_next = (data_byte == tgad_pkg::Bpp32);
            bpp_ok_next    = (data_byte == tgad_pkg::Bpp24) ||
                             (data_byte == tgad_pkg::Bpp32);
          end
          default: ;
        endcase
        if (hidx_eff != tgad_pkg::HdrFinal) begin
          header_index_next = hidx_eff + 5'd1;
        end else begin
          res_valid = 1'b1;
          if (!type_ok || !bpp_ok) begin
            res.kind       = tgad_pkg::KIND_ERROR;
            res.error_code = type_ok ? tgad_pkg::ErrBadDepth : tgad_pkg::ErrNotTruecolor;
            res.last       = 1'b1;
            phase_next     = tgad_pkg::PH_IDLE;
          end else begin
            res.kind           = tgad_pkg::KIND_HEADER;
            res.width          = width_reg;
            res.height         = height_reg;
            res.has_alpha      = bpp_is_32;
            pixels_left_next   = pixel_count;
            channel_index_next = 2'd0;
            held_next          = '0;
            if (width_reg == 16'd0 || height_reg == 16'd0) begin
              res.last   = 1'b1;
              phase_next = tgad_pkg::PH_IDLE;
            end else if (id_skip != 8'd0) begin
              phase_next = tgad_pkg::PH_IDSKIP;
            end else begin
              phase_next = tgad_pkg::PH_PIXELS;
            end
          end
        end
      end
      tgad_pkg::PH_IDSKIP: begin
        id_skip_next = id_skip - 8'd1;
        if (id_skip == 8'd1) phase_next = tgad_pkg::PH_PIXELS;
      end
      tgad_pkg::PH_PIXELS: begin
        case (channel_index)
          2'd0: held_new[7:0]   = data_byte;
          2'd1: held_new[15:8]  = data_byte;
          2'd2: held_new[23:16] = data_byte;
          default: ;
        endcase
        held_next          = held_new;
        channel_index_next = channel_index + 2'd1;
        emit_pixel = (channel_index == 2'd3) || (channel_index == 2'd2 && !bpp_is_32);
        if (emit_pixel) begin
          res_valid          = 1'b1;
          res.kind           = tgad_pkg::KIND_PIXEL;
          res.red            = held_new[23:16];
          res.green          = held_new[15:8];
          res.blue           = held_new[7:0];
          res.alpha          = (channel_index == 2'd3) ? data_byte : tgad_pkg::AlphaOpaque;
          channel_index_next = 2'd0;
          held_next          = '0;
          pixels_left_next   = pixels_left - 32'd1;
          if (pixels_left == 32'd1) begin
            res.last   = 1'b1;
            phase_next = tgad_pkg::PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tgad_pkg::PH_IDLE;
      header_index  <= '0;
      id_skip       <= '0;
      type_ok       <= 1'b0;
      bpp_ok        <= 1'b0;
      bpp_is_32     <= 1'b0;
      width_reg     <= '0;
      height_reg    <= '0;
      pixels_left   <= '0;
      channel_index <= '0;
      held          <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      id_skip       <= id_skip_next;
      type_ok       <= type_ok_next;
      bpp_ok        <= bpp_ok_next;
      bpp_is_32     <= bpp_is_32_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      pixels_left   <= pixels_left_next;
      channel_index <= channel_index_next;
      held          <= held_next;
    end
  end

endmodule

/* src/tgad_out_reg.sv */
module tgad_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tgad_pkg::result_t res,
  input  logic              stall,
  output logic              ready,
  output logic              valid,
  output tgad_pkg::result_t data
);

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) data <= res;
  end

endmodule

/* src/tga_uncompressed_decoder.sv */
// Uncompressed truecolor TGA decoder. Takes one file byte per transfer on the
// item channel and gives a header result, an error result or an RGBA pixel on
// the result channel. Sustained rate is one byte per clock while the result
// channel does not stall; a byte passes an input register and the parse logic
// into a result register. A stalled result holds the input register, which
// then stalls the item channel. The byte marked start_of_file restarts the
// parse; bytes after the last pixel or an error give nothing.
module tga_uncompressed_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [15:0] width,
  output logic [15:0] height,
  output logic        has_alpha,
  output logic        error_code,
  output logic        last
);

  logic              a_valid;
  logic [7:0]        a_byte;
  logic              a_sof;
  logic              o_ready;
  logic              fire;
  logic              res_valid;
  tgad_pkg::result_t res;
  tgad_pkg::result_t o_data;

  assign fire       = a_valid && o_ready;
  assign item_stall = a_valid && !o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!item_stall) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      a_byte <= data_byte;
      a_sof  <= start_of_file;
    end
  end

  tgad_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .data_byte     (a_byte),
    .start_of_file (a_sof),
    .res_valid     (res_valid),
    .res           (res)
  );

  tgad_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (fire && res_valid),
    .res   (res),
    .stall (result_stall),
    .ready (o_ready),
    .valid (result_valid),
    .data  (o_data)
  );

  assign kind       = o_data.kind;
  assign red        = o_data.red;
  assign green      = o_data.green;
  assign blue       = o_data.blue;
  assign alpha      = o_data.alpha;
  assign width      = o_data.width;
  assign height     = o_data.height;
  assign has_alpha  = o_data.has_alpha;
  assign error_code = o_data.error_code;
  assign last       = o_data.last;

endmodule
